>>> hdl/xmr_pkg.sv
// Shared types and constants of the XMODEM receive-to-flash block.
package xmr_pkg;

  // Protocol control codes.
  localparam logic [7:0] CODE_SOH = 8'd1;
  localparam logic [7:0] CODE_EOT = 8'd4;
  localparam logic [7:0] CODE_ACK = 8'd6;
  localparam logic [7:0] CODE_NAK = 8'd21;

  // Packet layout: two block-number bytes, the data bytes, then the checksum.
  localparam int unsigned HDR_BYTES  = 2;
  localparam int unsigned DATA_BYTES = 128;
  localparam logic [7:0]  HDR_END    = 8'(HDR_BYTES);
  localparam logic [7:0]  CHECK_POS  = 8'(HDR_BYTES + DATA_BYTES);

  // Configuration register indexes and data width.
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic        CFG_BASE   = 1'b0;
  localparam logic        CFG_PAD    = 1'b1;
  localparam logic [7:0]  PAD_RESET  = 8'd26;

  // Result kinds and input actions.
  localparam logic KIND_REPLY   = 1'b0;
  localparam logic KIND_RUN     = 1'b1;
  localparam logic ACTION_START = 1'b0;

  // Command queue between front and back.
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  typedef enum logic [1:0] {
    CMD_NAK,
    CMD_ACK,
    CMD_ACK_FIN,
    CMD_DATA
  } cmd_op_e;

  // One classified command: a reply, or a data byte with the pads before it.
  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
    logic [7:0] pads;
  } cmd_t;

  // Input transaction payload.
  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic        kind;
    logic [7:0]  reply_byte;
    logic [23:0] write_address;
    logic [7:0]  write_value;
    logic [7:0]  run_length;
    logic        finished;
    logic        last;
  } out_item_t;

endpackage

>>> hdl/xmr_front.sv
// Front end: tracks the packet position and classifies each byte into a command.
module xmr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  xmr_pkg::in_item_t item_i,
  input  logic [7:0]        pad_byte_i,
  output logic              cmd_push_o,
  output xmr_pkg::cmd_t     cmd_o
);

  logic       in_packet_q, in_packet_d;
  logic       done_q, done_d;
  logic [7:0] index_q, index_d;
  logic [7:0] pads_q, pads_d;

  // Next state and command for the accepted transaction.
  always_comb begin
    in_packet_d = in_packet_q;
    done_d      = done_q;
    index_d     = index_q;
    pads_d      = pads_q;
    cmd_push_o  = 1'b0;
    cmd_o.op    = xmr_pkg::CMD_NAK;
    cmd_o.data  = item_i.rx_byte;
    cmd_o.pads  = pads_q;
    if (accept_i) begin
      if (item_i.action == xmr_pkg::ACTION_START) begin
        in_packet_d = 1'b0;
        done_d      = 1'b0;
        index_d     = '0;
        pads_d      = '0;
        cmd_push_o  = 1'b1;
        cmd_o.op    = xmr_pkg::CMD_NAK;
      end else if (done_q) begin
        // Bytes after the end of transfer are dropped until a new start.
      end else if (!in_packet_q) begin
        if (item_i.rx_byte == xmr_pkg::CODE_SOH) begin
          in_packet_d = 1'b1;
          index_d     = '0;
          pads_d      = '0;
        end else if (item_i.rx_byte == xmr_pkg::CODE_EOT) begin
          done_d     = 1'b1;
          cmd_push_o = 1'b1;
          cmd_o.op   = xmr_pkg::CMD_ACK_FIN;
        end
      end else if (index_q >= xmr_pkg::CHECK_POS) begin
        in_packet_d = 1'b0;
        index_d     = '0;
        pads_d      = '0;
        cmd_push_o  = 1'b1;
        cmd_o.op    = xmr_pkg::CMD_ACK;
      end else begin
        if (index_q >= xmr_pkg::HDR_END) begin
          if (item_i.rx_byte == pad_byte_i) begin
            pads_d = pads_q + 8'd1;
          end else begin
            pads_d     = '0;
            cmd_push_o = 1'b1;
            cmd_o.op   = xmr_pkg::CMD_DATA;
          end
        end
        index_d = index_q + 8'd1;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      done_q      <= 1'b0;
      index_q     <= '0;
      pads_q      <= '0;
    end else begin
      in_packet_q <= in_packet_d;
      done_q      <= done_d;
      index_q     <= index_d;
      pads_q      <= pads_d;
    end
  end

endmodule

>>> hdl/xmr_cmd_fifo.sv
// Short command queue that decouples the front end from the back end.
module xmr_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xmr_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output xmr_pkg::cmd_t cmd_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = xmr_pkg::CMDQ_PTR_W;

  xmr_pkg::cmd_t         mem_q [xmr_pkg::CMDQ_DEPTH];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]         count_q;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == (PtrW + 1)'(xmr_pkg::CMDQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Storage; entries need no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (PtrW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (PtrW + 1)'(1);
      end
    end
  end

endmodule

>>> hdl/xmr_back.sv
// Back end: turns commands into replies and flash write runs, owns the write offset.
module xmr_back #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  xmr_pkg::cmd_t      cmd_i,
  input  logic               cmd_empty_i,
  output logic               cmd_pop_o,
  input  logic [23:0]        base_address_i,
  input  logic [7:0]         pad_byte_i,
  output xmr_pkg::out_item_t out_item_o,
  output logic               empty_o,
  input  logic               pop_i
);

  logic                  out_valid_q;
  xmr_pkg::out_item_t    out_q, out_d;
  logic                  phase_q, phase_d;
  logic [ADDR_BITS-1:0]  offset_q, offset_d;
  logic [ADDR_BITS-1:0]  run_addr;
  logic                  out_ready, produce;

  assign out_ready  = !out_valid_q || pop_i;
  assign produce    = out_ready && !cmd_empty_i;
  assign run_addr   = ADDR_BITS'(base_address_i) + offset_q;
  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;

  // Result formation for the command at the head of the queue.
  always_comb begin
    out_d      = '0;
    phase_d    = phase_q;
    offset_d   = offset_q;
    cmd_pop_o  = 1'b0;
    if (produce) begin
      unique case (cmd_i.op) inside
        xmr_pkg::CMD_NAK: begin
          out_d.kind       = xmr_pkg::KIND_REPLY;
          out_d.reply_byte = xmr_pkg::CODE_NAK;
          out_d.last       = 1'b1;
          offset_d         = '0;
          cmd_pop_o        = 1'b1;
        end
        xmr_pkg::CMD_ACK, xmr_pkg::CMD_ACK_FIN: begin
          out_d.kind       = xmr_pkg::KIND_REPLY;
          out_d.reply_byte = xmr_pkg::CODE_ACK;
          out_d.finished   = (cmd_i.op == xmr_pkg::CMD_ACK_FIN);
          out_d.last       = 1'b1;
          cmd_pop_o        = 1'b1;
        end
        xmr_pkg::CMD_DATA: begin
          out_d.kind          = xmr_pkg::KIND_RUN;
          out_d.write_address = 24'(run_addr);
          if (!phase_q && cmd_i.pads != '0) begin
            // Flush the held pad bytes first; the command stays at the head.
            out_d.write_value = pad_byte_i;
            out_d.run_length  = cmd_i.pads;
            out_d.last        = 1'b0;
            offset_d          = offset_q + ADDR_BITS'(cmd_i.pads);
            phase_d           = 1'b1;
          end else begin
            out_d.write_value = cmd_i.data;
            out_d.run_length  = 8'd1;
            out_d.last        = 1'b1;
            offset_d          = offset_q + ADDR_BITS'(1);
            phase_d           = 1'b0;
            cmd_pop_o         = 1'b1;
          end
        end
        default: begin
          cmd_pop_o = 1'b1;
        end
      endcase
    end
  end

  // Output register and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      offset_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      offset_q <= offset_d;
      if (out_ready) begin
        out_valid_q <= produce;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (produce) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  // The second half of a split data command always sits at the queue head.
  a_phase_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (!cmd_empty_i && cmd_i.op == xmr_pkg::CMD_DATA))
    else $error("pad flush pending without a data command at the head");

  // A finished second half clears the phase.
  a_phase_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q && out_ready) |=> !phase_q)
    else $error("pad flush phase did not clear");

  // Every write run covers at least one byte.
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == xmr_pkg::KIND_RUN) |-> (out_q.run_length != '0))
    else $error("write run of length zero");

  // A split data command never releases the queue entry on its first half.
  a_split_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (produce && !phase_q && cmd_i.op == xmr_pkg::CMD_DATA && cmd_i.pads != '0)
      |-> !cmd_pop_o)
    else $error("data command popped before its pad run");
`endif

endmodule

>>> hdl/xmodem_receive_to_flash_core.sv
// Top level of the XMODEM receive-to-flash block.
// Usage:
//   Input channel (push, full, in_item_i): one transaction per received byte
//   (action 1) or per transfer start (action 0); a byte may be pushed every
//   cycle while full is low.
//   Result channel (empty, pop, out_item_o): replies (NAK on start, ACK after
//   the checksum byte or on EOT with finished set) and flash write runs at
//   base_address plus the running offset. A non-pad data byte that follows a
//   held run of pad bytes yields two results: the pad fill run, then the byte.
//   Each result passes the command queue, then the output register, on its
//   way to the result ports. Throughput: one input per cycle while full is
//   low and one result per cycle while pop keeps up; the back end serves one
//   command per cycle, but a data byte with a pad flush holds the queue head
//   while its fill run goes out first, which sets the sustained rate.
//   When the result side stalls, the four-entry command queue fills and full
//   rises; bytes that cause no result are also held off while it is full.
//   Reset clears the packet state, the offset and the queues; base_address
//   resets to 0 and pad_byte to 26. Write configuration only while idle.
module xmodem_receive_to_flash_core #(
  parameter int unsigned ADDR_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  xmr_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output xmr_pkg::out_item_t out_item_o
);

  logic [23:0]   base_address_q;
  logic [7:0]    pad_byte_q;
  logic          accept;
  logic          cmd_push, cmd_pop, cmd_empty;
  xmr_pkg::cmd_t cmd_in, cmd_head;

  assign accept = push && !full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_address_q <= '0;
      pad_byte_q     <= xmr_pkg::PAD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        xmr_pkg::CFG_BASE: base_address_q <= cfg_wdata_i;
        xmr_pkg::CFG_PAD:  pad_byte_q     <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  xmr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .pad_byte_i (pad_byte_q),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  xmr_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_head),
    .full_o  (full),
    .empty_o (cmd_empty)
  );

  xmr_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_head),
    .cmd_empty_i    (cmd_empty),
    .cmd_pop_o      (cmd_pop),
    .base_address_i (base_address_q),
    .pad_byte_i     (pad_byte_q),
    .out_item_o     (out_item_o),
    .empty_o        (empty),
    .pop_i          (pop)
  );

endmodule

>>> verif/xmodem_receive_to_flash_core_tb.sv
// Self-checking testbench for the XMODEM receive-to-flash core.
module xmodem_receive_to_flash_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACTION_BYTE = !xmr_pkg::ACTION_START;
  localparam int   FRAME_BYTES = 132;
  localparam int   STALL_LIMIT = 2000;
  localparam int   PHASE_ITEMS = 250;
  localparam int   MAX_PRINTS  = 40;

  // Clock, reset and block ports.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic               cfg_idx_i   = xmr_pkg::CFG_BASE;
  logic [23:0]        cfg_wdata_i = '0;
  logic               push        = 1'b0;
  logic               full;
  xmr_pkg::in_item_t  in_item     = '0;
  logic               empty;
  logic               pop         = 1'b0;
  xmr_pkg::out_item_t out_item;

  always #5 clk_i = ~clk_i;

  xmodem_receive_to_flash_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  // Byte stream waiting to be sent and replies/runs waiting to be seen.
  xmr_pkg::in_item_t  rx_stream_q[$];
  xmr_pkg::out_item_t awaited_q[$];
  int        items_queued = 0;
  int        items_taken  = 0;
  int        phase_items  = 0;
  int        err_cnt      = 0;
  bit        allow_gaps   = 1'b1;

  // Receiver state as the block should hold it.
  logic [23:0] base_cfg    = '0;
  logic [7:0]  pad_cfg     = xmr_pkg::PAD_RESET;
  logic        in_pkt      = 1'b0;
  logic        xfer_done   = 1'b0;
  logic [7:0]  pkt_pos     = '0;
  logic [7:0]  held_pads   = '0;
  logic [23:0] flash_off   = '0;

  task automatic report(string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  function automatic xmr_pkg::out_item_t reply_result(logic [7:0] code, logic fin);
    xmr_pkg::out_item_t r;
    r = '0;
    r.kind       = xmr_pkg::KIND_REPLY;
    r.reply_byte = code;
    r.finished   = fin;
    return r;
  endfunction

  // A flash write run at the current offset; the offset moves past it.
  function automatic xmr_pkg::out_item_t write_run(logic [7:0] value, logic [7:0] len);
    xmr_pkg::out_item_t r;
    r = '0;
    r.kind          = xmr_pkg::KIND_RUN;
    r.write_address = base_cfg + flash_off;
    r.write_value   = value;
    r.run_length    = len;
    flash_off       = flash_off + 24'(len);
    return r;
  endfunction

  // Works out the replies and write runs that one accepted transaction causes.
  task automatic predict_receiver(xmr_pkg::in_item_t it);
    xmr_pkg::out_item_t res[2];
    int                 n;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    if (it.action == xmr_pkg::ACTION_START) begin
      in_pkt    = 1'b0;
      xfer_done = 1'b0;
      pkt_pos   = '0;
      held_pads = '0;
      flash_off = '0;
      res[n] = reply_result(xmr_pkg::CODE_NAK, 1'b0);
      n++;
    end else if (xfer_done) begin
      // Bytes after the end of a transfer wait for the next start.
    end else if (!in_pkt) begin
      if (it.rx_byte == xmr_pkg::CODE_SOH) begin
        in_pkt    = 1'b1;
        pkt_pos   = '0;
        held_pads = '0;
      end else if (it.rx_byte == xmr_pkg::CODE_EOT) begin
        xfer_done = 1'b1;
        res[n] = reply_result(xmr_pkg::CODE_ACK, 1'b1);
        n++;
      end
    end else if (pkt_pos >= xmr_pkg::CHECK_POS) begin
      // Checksum byte: trailing pads are dropped and the packet is acknowledged.
      in_pkt    = 1'b0;
      pkt_pos   = '0;
      held_pads = '0;
      res[n] = reply_result(xmr_pkg::CODE_ACK, 1'b0);
      n++;
    end else begin
      if (pkt_pos >= xmr_pkg::HDR_END) begin
        if (it.rx_byte == pad_cfg) begin
          held_pads = held_pads + 8'd1;
        end else begin
          if (held_pads != 0) begin
            res[n] = write_run(pad_cfg, held_pads);
            n++;
            held_pads = '0;
          end
          res[n] = write_run(it.rx_byte, 8'd1);
          n++;
        end
      end
      pkt_pos = pkt_pos + 8'd1;
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) awaited_q.push_back(res[i]);
  endtask

  task automatic check_field(string name, logic [23:0] got, logic [23:0] want);
    if (got !== want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
  endtask

  // Compares one result transaction with the oldest awaited one.
  task automatic check_result(xmr_pkg::out_item_t got);
    xmr_pkg::out_item_t want;
    if (awaited_q.size() == 0) begin
      report($sformatf("result %h arrived with nothing awaited", got));
      return;
    end
    want = awaited_q.pop_front();
    check_field("kind", 24'(got.kind), 24'(want.kind));
    check_field("reply_byte", 24'(got.reply_byte), 24'(want.reply_byte));
    check_field("write_address", got.write_address, want.write_address);
    check_field("write_value", 24'(got.write_value), 24'(want.write_value));
    check_field("run_length", 24'(got.run_length), 24'(want.run_length));
    check_field("finished", 24'(got.finished), 24'(want.finished));
    check_field("last", 24'(got.last), 24'(want.last));
  endtask

  // Sender: presents queued bytes, holds while full, idles in random bursts.
  int send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push    <= 1'b0;
      in_item <= '0;
    end else begin
      if (push && !full) begin
        predict_receiver(in_item);
        items_taken++;
      end
      if (!(push && full)) begin
        if (send_gap != 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (allow_gaps && rx_stream_q.size() != 0 && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(0, 12);
          push <= 1'b0;
        end else if (rx_stream_q.size() != 0) begin
          push    <= 1'b1;
          in_item <= rx_stream_q.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result side: checks each popped transaction, stalls in random bursts.
  int pop_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(out_item);
      if (pop_gap != 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (allow_gaps && $urandom_range(0, 15) == 0) begin
        pop_gap = $urandom_range(0, 12);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("** xmodem_receive_to_flash_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_item(logic act, logic [7:0] b);
    xmr_pkg::in_item_t it;
    it.action  = act;
    it.rx_byte = b;
    rx_stream_q.push_back(it);
    items_queued++;
    phase_items++;
  endtask

  // Queues one packet frame, or only its first cut bytes for a broken one.
  task automatic add_packet(int cut);
    logic [7:0] frame[FRAME_BYTES];
    int         mode;
    int         k;
    mode = $urandom_range(0, 4);
    k    = $urandom_range(1, 128);
    if (mode == 4) k = ($urandom_range(0, 1) == 0) ? 127 : $urandom_range(1, 126);
    frame[0] = xmr_pkg::CODE_SOH;
    for (int i = 1; i < FRAME_BYTES; i++) frame[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < 128; i++) begin
      case (mode)
        1: if ($urandom_range(0, 2) == 0) frame[3+i] = pad_cfg;
        2: if (i >= 128 - k) frame[3+i] = pad_cfg;
        3: frame[3+i] = pad_cfg;
        4: begin
          // A run of pads, then a byte that forces the fill run out.
          if (i < k) frame[3+i] = pad_cfg;
          else if (i == k && frame[3+i] == pad_cfg) frame[3+i] = pad_cfg ^ 8'h80;
        end
        default: ;
      endcase
    end
    for (int i = 0; i < cut; i++) add_item(ACTION_BYTE, frame[i]);
  endtask

  // Queues one transfer: start, packets with some noise, then end of transmission unless a packet is cut short.
  task automatic add_transfer();
    int npk;
    npk = $urandom_range(1, 2);
    add_item(xmr_pkg::ACTION_START, 8'($urandom_range(0, 255)));
    for (int p = 0; p < npk; p++) begin
      if ($urandom_range(0, 3) == 0) add_item(ACTION_BYTE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) begin
        add_packet($urandom_range(1, FRAME_BYTES - 1));
        return;
      end
      add_packet(FRAME_BYTES);
    end
    add_item(ACTION_BYTE, xmr_pkg::CODE_EOT);
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) add_item(ACTION_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  // Waits until every byte is taken and every result seen, then lets the
  // pipeline settle so bytes without results are done as well.
  task automatic wait_idle();
    while (items_taken != items_queued || awaited_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [23:0] base, logic [7:0] pad);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= xmr_pkg::CFG_BASE;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_idx_i   <= xmr_pkg::CFG_PAD;
    cfg_wdata_i <= {16'd0, pad};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    base_cfg = base;
    pad_cfg  = pad;
  endtask

  // Main sequence: directed cases, then randomized phases under several settings.
  initial begin
    logic [23:0] bases[7];
    logic [7:0]  pads[7];
    bases = '{24'hFFFFFF, 24'hFFFF00, 24'h000000, 24'($urandom_range(0, 24'hFFFFFF)),
              24'($urandom_range(0, 24'hFFFFFF)), 24'hFFFF80,
              24'($urandom_range(0, 24'hFFFFFF))};
    pads  = '{8'h00, 8'hFF, xmr_pkg::PAD_RESET, 8'($urandom_range(0, 255)),
              xmr_pkg::CODE_SOH, xmr_pkg::PAD_RESET, 8'($urandom_range(0, 255))};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: bytes before any start, finish handling, a short packet
    // with a pad flush, trailing pads, and a start in the middle of a packet.
    add_item(ACTION_BYTE, 8'hAB);
    add_item(ACTION_BYTE, xmr_pkg::CODE_EOT);
    add_item(ACTION_BYTE, 8'hFF);
    add_item(ACTION_BYTE, xmr_pkg::CODE_SOH);
    add_item(xmr_pkg::ACTION_START, 8'hFF);
    add_item(xmr_pkg::ACTION_START, 8'h00);
    add_item(ACTION_BYTE, 8'h00);
    add_item(ACTION_BYTE, xmr_pkg::CODE_SOH);
    add_item(ACTION_BYTE, 8'hFF);
    add_item(ACTION_BYTE, 8'h00);
    add_item(ACTION_BYTE, xmr_pkg::PAD_RESET);
    add_item(ACTION_BYTE, xmr_pkg::PAD_RESET);
    add_item(ACTION_BYTE, 8'hFF);
    add_item(ACTION_BYTE, 8'h00);
    add_item(ACTION_BYTE, xmr_pkg::CODE_EOT);
    add_item(ACTION_BYTE, xmr_pkg::PAD_RESET);
    add_item(xmr_pkg::ACTION_START, 8'h5A);
    add_item(ACTION_BYTE, xmr_pkg::CODE_EOT);
    wait_idle();

    // Random phases; the sender pauses at each boundary until all results are in.
    for (int ph = 0; ph < 7; ph++) begin
      write_cfg(bases[ph], pads[ph]);
      if (ph == 6) allow_gaps = 1'b0;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) add_transfer();
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (awaited_q.size() != 0) report($sformatf("%0d results never arrived", awaited_q.size()));
    if (err_cnt == 0) begin
      $display("** xmodem_receive_to_flash_core: PASSED **");
    end else begin
      $display("** xmodem_receive_to_flash_core: FAILED **");
    end
    $finish;
  end

endmodule
